FILE: rtl/ttti_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttti_pkg
// Shared constants and types for the two-table thickness interpolator.
// ----------------------------------------------------------------------------
package ttti_pkg;
	localparam int POINTS = 20;
	localparam int IDX_W = $clog2(POINTS);

	localparam logic [0:0] OP_MEASURE = 1'b0;
	localparam logic [0:0] OP_CALIB   = 1'b1;

	localparam logic [1:0] METAL_FE = 2'd0;
	localparam logic [1:0] METAL_AL = 2'd1;

	localparam logic [2:0] CLS_FE    = 3'd0;
	localparam logic [2:0] CLS_AIR   = 3'd1;
	localparam logic [2:0] CLS_AL    = 3'd2;
	localparam logic [2:0] CLS_NO_FE = 3'd3;
	localparam logic [2:0] CLS_NO_AL = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_METAL = 2'd2;

	localparam logic [0:0] REG_AIR_FREQ   = 1'b0;
	localparam logic [0:0] REG_AIR_MARGIN = 1'b1;

	localparam logic [15:0] AIR_MARGIN_RST = 16'd500;
	localparam logic [15:0] THICK_RST      = 16'hFFFF;

	typedef struct packed {
		logic        calib;
		logic        bad_index;
		logic [15:0] frequency;
		logic [15:0] gap_um;
		logic [7:0]  point_index;
		logic [1:0]  metal;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  result_class;
		logic [15:0] thickness_um;
		logic [1:0]  calib_status;
	} res_t;
endpackage

FILE: rtl/ttti_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttti_front
// Input stage: classify each beat and push it into a two-entry queue.
// ----------------------------------------------------------------------------
module ttti_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid,
	output logic            stall,
	input  logic            opcode,
	input  logic [15:0]     frequency,
	input  logic [15:0]     gap_um,
	input  logic [7:0]      point_index,
	input  logic [1:0]      metal,
	output logic            q_valid,
	output ttti_pkg::cmd_t  q_cmd,
	input  logic            q_pop
);
	import ttti_pkg::*;

	cmd_t        mem_q [2];
	logic        wr_q, rd_q;
	logic [1:0]  cnt_q;
	logic        push;
	cmd_t        c;

	assign stall = (cnt_q == 2'd2);
	assign push = valid && !stall;
	assign q_valid = (cnt_q != 2'd0);
	assign q_cmd = mem_q[rd_q];

	always_comb begin
		c.calib = (opcode == OP_CALIB);
		c.bad_index = ({24'd0, point_index} >= POINTS);
		c.frequency = frequency;
		c.gap_um = gap_um;
		c.point_index = point_index;
		c.metal = metal;
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (q_pop)
				rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule

FILE: rtl/ttti_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttti_div
// Restoring divider, one quotient bit per cycle, magnitudes only.
// ----------------------------------------------------------------------------
module ttti_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [32:0] dividend,
	input  logic [16:0] divisor,
	output logic        busy,
	output logic [32:0] quotient
);
	logic [32:0] quo_q;
	logic [16:0] rem_q;
	logic [16:0] den_q;
	logic [5:0]  cnt_q;
	logic [17:0] trial;

	assign busy = (cnt_q != 6'd0);
	assign quotient = quo_q;
	assign trial = {rem_q, quo_q[32]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 6'd0;
		end else if (start) begin
			cnt_q <= 6'd33;
		end else if (busy) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= 17'd0;
			den_q <= divisor;
		end else if (busy) begin
			if (!trial[17]) begin
				rem_q <= trial[16:0];
				quo_q <= {quo_q[31:0], 1'b1};
			end else begin
				rem_q <= {rem_q[15:0], quo_q[32]};
				quo_q <= {quo_q[31:0], 1'b0};
			end
		end
	end
endmodule

FILE: rtl/ttti_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttti_back
// Execution: table writes, table scans, interpolation and air classing.
// ----------------------------------------------------------------------------
module ttti_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  ttti_pkg::cmd_t  q_cmd,
	output logic            q_pop,
	input  logic [15:0]     air_frequency,
	input  logic [15:0]     air_margin,
	output logic            out_valid,
	output ttti_pkg::res_t  out_res,
	input  logic            out_stall
);
	import ttti_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_FE    = 7'b0000010,
		S_AL    = 7'b0000100,
		S_MUL   = 7'b0001000,
		S_DIV   = 7'b0010000,
		S_FIN   = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	state_t state_q;
	logic [15:0] fe_f [POINTS];
	logic [15:0] fe_t [POINTS];
	logic [15:0] al_f [POINTS];
	logic [15:0] al_t [POINTS];
	logic [POINTS-1:0] fe_tv_q, al_tv_q;
	logic [IDX_W-1:0] fe_last_q, al_last_q;
	logic [IDX_W-1:0] idx_q;
	cmd_t cmd_q;
	logic is_al_q;
	logic [15:0] f1_q, f2_q, m1_q, m2_q;
	logic [15:0] rd_f, rd_t;
	logic neg_q;
	logic div_start, div_busy;
	logic [32:0] div_quo;
	logic hit;
	logic [16:0] df;
	logic signed [16:0] dm;
	logic signed [17:0] fs, lo, hi;
	logic [2:0] air_cls;
	logic [15:0] quo16;
	logic signed [17:0] sdf;
	logic signed [17:0] sden;
	logic signed [35:0] sprod;
	logic [35:0] aprod;
	logic [17:0] aden;

	assign q_pop = (state_q == S_IDLE) && q_valid && !out_valid;
	assign rd_f = is_al_q ? (al_tv_q[idx_q] ? al_f[idx_q] : 16'd0)
	                      : (fe_tv_q[idx_q] ? fe_f[idx_q] : 16'd0);
	assign rd_t = is_al_q ? (al_tv_q[idx_q] ? al_t[idx_q] : THICK_RST)
	                      : (fe_tv_q[idx_q] ? fe_t[idx_q] : THICK_RST);
	assign hit = is_al_q ? (cmd_q.frequency >= rd_f) : (cmd_q.frequency <= rd_f);
	assign df = {1'b0, cmd_q.frequency} - {1'b0, f1_q};
	assign dm = $signed({1'b0, m2_q}) - $signed({1'b0, m1_q});
	assign div_start = (state_q == S_MUL);
	assign fs = $signed({2'b00, cmd_q.frequency});
	assign lo = $signed({2'b00, air_frequency}) - $signed({2'b00, air_margin});
	assign hi = $signed({2'b00, air_frequency}) + $signed({2'b00, air_margin});
	assign quo16 = neg_q ? (16'd0 - div_quo[15:0]) : div_quo[15:0];

	assign sdf = $signed({df[16], df});
	assign sden = $signed({2'b00, f2_q}) - $signed({2'b00, f1_q});
	assign sprod = sdf * $signed({dm[16], dm});
	assign aprod = sprod[35] ? (36'd0 - sprod) : sprod;
	assign aden = sden[17] ? (18'd0 - sden) : sden;

	always_comb begin
		priority if (fs < lo && fe_last_q == '0)
			air_cls = CLS_NO_FE;
		else if (fs > hi && al_last_q == '0)
			air_cls = CLS_NO_AL;
		else
			air_cls = CLS_AIR;
	end

	ttti_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(aprod[32:0]), .divisor(aden[16:0]), .busy(div_busy),
		.quotient(div_quo)
	);

	always_ff @(posedge clk) begin
		if (q_pop && q_cmd.calib && !q_cmd.bad_index) begin
			if (q_cmd.metal == METAL_FE) begin
				fe_f[q_cmd.point_index[IDX_W-1:0]] <= q_cmd.frequency;
				fe_t[q_cmd.point_index[IDX_W-1:0]] <= q_cmd.gap_um;
			end else if (q_cmd.metal == METAL_AL) begin
				al_f[q_cmd.point_index[IDX_W-1:0]] <= q_cmd.frequency;
				al_t[q_cmd.point_index[IDX_W-1:0]] <= q_cmd.gap_um;
			end
		end
		if (q_pop)
			cmd_q <= q_cmd;
		if ((state_q == S_FE || state_q == S_AL) && hit && idx_q != '0) begin
			m2_q <= rd_t;
			f2_q <= rd_f;
		end
		if ((state_q == S_FE || state_q == S_AL) && !hit) begin
			f1_q <= rd_f;
			m1_q <= rd_t;
		end
		if (state_q == S_MUL) begin
			neg_q <= sprod[35] ^ sden[17];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fe_tv_q <= '0;
			al_tv_q <= '0;
			fe_last_q <= '0;
			al_last_q <= '0;
			idx_q <= '0;
			is_al_q <= 1'b0;
			out_valid <= 1'b0;
			out_res <= '0;
		end else begin
			if (out_valid && !out_stall)
				out_valid <= 1'b0;
			unique case (state_q)
			S_IDLE: begin
				if (q_pop) begin
					if (q_cmd.calib) begin
						out_valid <= 1'b1;
						out_res.result_class <= CLS_FE;
						out_res.thickness_um <= 16'd0;
						if (q_cmd.bad_index)
							out_res.calib_status <= ST_RANGE;
						else if (q_cmd.metal == METAL_FE) begin
							out_res.calib_status <= ST_OK;
							fe_tv_q[q_cmd.point_index[IDX_W-1:0]] <= 1'b1;
							fe_last_q <= q_cmd.point_index[IDX_W-1:0];
						end else if (q_cmd.metal == METAL_AL) begin
							out_res.calib_status <= ST_OK;
							al_tv_q[q_cmd.point_index[IDX_W-1:0]] <= 1'b1;
							al_last_q <= q_cmd.point_index[IDX_W-1:0];
						end else
							out_res.calib_status <= ST_METAL;
					end else begin
						idx_q <= '0;
						is_al_q <= 1'b0;
						state_q <= S_FE;
					end
				end
			end
			S_FE, S_AL: begin
				if ((state_q == S_FE && fe_last_q == '0) ||
				    (state_q == S_AL && al_last_q == '0)) begin
					if (state_q == S_FE) begin
						is_al_q <= 1'b1;
						idx_q <= '0;
						state_q <= S_AL;
					end else begin
						out_res <= '{air_cls, 16'd0, ST_OK};
						state_q <= S_OUT;
					end
				end else if (hit) begin
					if (idx_q == '0) begin
						out_res <= '{is_al_q ? CLS_AL : CLS_FE, 16'd0, ST_OK};
						state_q <= S_OUT;
					end else
						state_q <= S_MUL;
				end else if (idx_q == (is_al_q ? al_last_q : fe_last_q)) begin
					if (state_q == S_FE) begin
						is_al_q <= 1'b1;
						idx_q <= '0;
						state_q <= S_AL;
					end else begin
						out_res <= '{air_cls, 16'd0, ST_OK};
						state_q <= S_OUT;
					end
				end else
					idx_q <= idx_q + 1'b1;
			end
			S_MUL: begin
				state_q <= S_DIV;
			end
			S_DIV: begin
				if (!div_busy)
					state_q <= S_FIN;
			end
			S_FIN: begin
				out_res <= '{is_al_q ? CLS_AL : CLS_FE, quo16 + m1_q, ST_OK};
				state_q <= S_OUT;
			end
			S_OUT: begin
				if (!out_valid) begin
					out_valid <= 1'b1;
					state_q <= S_IDLE;
				end
			end
			default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: rtl/two_table_thickness_interpolator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_table_thickness_interpolator
// Piecewise linear thickness lookup over ferrous and aluminum tables.
// ----------------------------------------------------------------------------
// One item is worked at a time behind a two-entry input queue, so input beats
// can arrive while the back end works. A calibrate beat updates its table
// and registers its result as it leaves the queue. A measure beat scans the
// ferrous then the aluminum table one point per cycle; a hit between two
// points goes through the product state, the bit-serial divider and the
// finish state. A hit on the first point of a table or an air result skips
// the divider. The next item starts once the result beat has been taken.
module two_table_thickness_interpolator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [15:0] frequency,
	input  logic [15:0] gap_um,
	input  logic [7:0]  point_index,
	input  logic [1:0]  metal,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  result_class,
	output logic [15:0] thickness_um,
	output logic [1:0]  calib_status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import ttti_pkg::*;

	logic        q_valid, q_pop;
	cmd_t        q_cmd;
	res_t        res;
	logic [15:0] air_freq_q, air_margin_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			air_freq_q <= 16'd0;
			air_margin_q <= AIR_MARGIN_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
			REG_AIR_FREQ:   air_freq_q <= cfg_data;
			REG_AIR_MARGIN: air_margin_q <= cfg_data;
			default: ;
			endcase
		end
	end

	ttti_front u_front (
		.clk(clk), .arst_n(arst_n), .valid(in_valid), .stall(in_stall),
		.opcode(opcode), .frequency(frequency), .gap_um(gap_um),
		.point_index(point_index), .metal(metal),
		.q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop)
	);

	ttti_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop),
		.air_frequency(air_freq_q), .air_margin(air_margin_q),
		.out_valid(out_valid), .out_res(res), .out_stall(out_stall)
	);

	assign result_class = res.result_class;
	assign thickness_um = res.thickness_um;
	assign calib_status = res.calib_status;
endmodule

FILE: rtl/ttti_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttti_props
// Port-level properties of the interpolator.
// ----------------------------------------------------------------------------
module ttti_props (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  result_class,
	input logic [15:0] thickness_um,
	input logic [1:0]  calib_status
);
	import ttti_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(thickness_um))
		else $error("result dropped under stall");
	a_cls: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> result_class <= CLS_NO_AL)
		else $error("bad class");
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && calib_status != ST_OK |-> result_class == CLS_FE && thickness_um == 16'd0)
		else $error("status on measure");
	a_thick: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_class != CLS_FE && result_class != CLS_AL |-> thickness_um == 16'd0)
		else $error("thickness without metal");
endmodule

bind two_table_thickness_interpolator ttti_props u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_stall(out_stall),
	.result_class(result_class), .thickness_um(thickness_um),
	.calib_status(calib_status)
);

FILE: verif/ttti_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttti_checker
// Watches the input, result and register channels of the thickness
// interpolator, keeps its own copy of both calibration tables and the air
// settings, predicts each result beat and compares it field by field.
// ----------------------------------------------------------------------------
module ttti_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        opcode,
	input  logic [15:0] frequency,
	input  logic [15:0] gap_um,
	input  logic [7:0]  point_index,
	input  logic [1:0]  metal,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  result_class,
	input  logic [15:0] thickness_um,
	input  logic [1:0]  calib_status,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          fail_count,
	output int          pending
);
	import ttti_pkg::*;

	logic [15:0] air_freq_q;
	logic [15:0] air_margin_q;
	logic [15:0] fe_f [POINTS];
	logic [15:0] fe_t [POINTS];
	logic [15:0] al_f [POINTS];
	logic [15:0] al_t [POINTS];
	int          fe_end;
	int          al_end;
	res_t        expected_results [$];

	function automatic logic [15:0] interp(longint f, longint f1, longint f2,
		longint m1, longint m2);
		longint m;
		m = (f - f1) * (m2 - m1) / (f2 - f1) + m1;
		return m[15:0];
	endfunction

	function automatic res_t predict_beat(logic op, logic [15:0] f, logic [15:0] g,
		logic [7:0] idx, logic [1:0] mt);
		res_t r;
		logic hit;
		int   lo;
		int   hi;
		r = '{result_class: CLS_AIR, thickness_um: 16'd0, calib_status: ST_OK};
		if (op == OP_CALIB) begin
			r.result_class = CLS_FE;
			if (idx >= POINTS) r.calib_status = ST_RANGE;
			else if (mt == METAL_FE) begin
				fe_f[idx] = f;
				fe_t[idx] = g;
				fe_end = idx;
			end else if (mt == METAL_AL) begin
				al_f[idx] = f;
				al_t[idx] = g;
				al_end = idx;
			end else r.calib_status = ST_METAL;
			return r;
		end
		hit = 1'b0;
		if (fe_end != 0) begin
			if (f <= fe_f[0]) begin
				r.result_class = CLS_FE;
				hit = 1'b1;
			end
			for (int i = 1; !hit && i <= fe_end; i++)
				if (f <= fe_f[i]) begin
					r.result_class = CLS_FE;
					r.thickness_um = interp(f, fe_f[i-1], fe_f[i], fe_t[i-1], fe_t[i]);
					hit = 1'b1;
				end
		end
		if (!hit && al_end != 0) begin
			if (f >= al_f[0]) begin
				r.result_class = CLS_AL;
				hit = 1'b1;
			end
			for (int i = 1; !hit && i <= al_end; i++)
				if (f >= al_f[i]) begin
					r.result_class = CLS_AL;
					r.thickness_um = interp(f, al_f[i-1], al_f[i], al_t[i-1], al_t[i]);
					hit = 1'b1;
				end
		end
		if (!hit) begin
			lo = int'(air_freq_q) - int'(air_margin_q);
			hi = int'(air_freq_q) + int'(air_margin_q);
			if (int'(f) < lo && fe_end == 0) r.result_class = CLS_NO_FE;
			else if (int'(f) > hi && al_end == 0) r.result_class = CLS_NO_AL;
		end
		return r;
	endfunction

	assign pending = expected_results.size();

	always @(posedge clk or negedge arst_n) begin
		res_t e;
		if (!arst_n) begin
			air_freq_q   <= 16'd0;
			air_margin_q <= AIR_MARGIN_RST;
			for (int i = 0; i < POINTS; i++) begin
				fe_f[i] = 16'd0;
				fe_t[i] = THICK_RST;
				al_f[i] = 16'd0;
				al_t[i] = THICK_RST;
			end
			fe_end = 0;
			al_end = 0;
			fail_count <= 0;
			expected_results.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_AIR_FREQ) air_freq_q <= cfg_data;
				else air_margin_q <= cfg_data;
			end
			if (in_valid && !in_stall)
				expected_results.push_back(predict_beat(opcode, frequency, gap_um,
					point_index, metal));
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result beat class %0d thick %0d status %0d",
						$time, result_class, thickness_um, calib_status);
					fail_count <= fail_count + 1;
				end else begin
					e = expected_results.pop_front();
					if (e.result_class !== result_class || e.thickness_um !== thickness_um
						|| e.calib_status !== calib_status) begin
						$display("%0t: expected class %0d thick %0d status %0d, got %0d %0d %0d",
							$time, e.result_class, e.thickness_um, e.calib_status,
							result_class, thickness_um, calib_status);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

FILE: verif/tb_two_table_thickness_interpolator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_table_thickness_interpolator
// Drives calibrate and measure beats and register writes into the
// interpolator under varying idle and stall pressure; the checker predicts
// and compares every result beat.
// ----------------------------------------------------------------------------
module tb_two_table_thickness_interpolator;
	import ttti_pkg::*;

	localparam int WATCHDOG = 20000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        opcode;
	logic [15:0] frequency;
	logic [15:0] gap_um;
	logic [7:0]  point_index;
	logic [1:0]  metal;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  result_class;
	logic [15:0] thickness_um;
	logic [1:0]  calib_status;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [0:0]  cfg_index;
	logic [15:0] cfg_data;
	int          fail_count;
	int          pending;
	int          idle_pct;
	int          stall_pct;
	int          quiet = 0;

	two_table_thickness_interpolator DUT (.*);

	ttti_checker u_checker (.*);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= WATCHDOG) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic send_beat(logic op, logic [15:0] f, logic [15:0] g, logic [7:0] idx,
		logic [1:0] mt);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		opcode      <= op;
		frequency   <= f;
		gap_um      <= g;
		point_index <= idx;
		metal       <= mt;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic run_random(int n);
		logic [15:0] base;
		int          len;
		int          k;
		k = 0;
		while (k < n) begin
			case ($urandom_range(9))
				0, 1, 2: begin
					// ascending ferrous table
					len  = $urandom_range(2, 6);
					base = $urandom_range(0, 30000);
					for (int i = 0; i < len; i++)
						send_beat(OP_CALIB, base + 16'(i * $urandom_range(1, 5000)),
							16'($urandom), 8'(i), METAL_FE);
					k += len;
				end
				3, 4: begin
					// descending aluminum table
					len  = $urandom_range(2, 6);
					base = $urandom_range(35535, 65535);
					for (int i = 0; i < len; i++)
						send_beat(OP_CALIB, base - 16'(i * $urandom_range(1, 5000)),
							16'($urandom), 8'(i), METAL_AL);
					k += len;
				end
				5: begin
					send_beat(OP_CALIB, 16'($urandom), 16'($urandom),
						($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(19)),
						2'($urandom));
					k++;
				end
				default: begin
					send_beat(OP_MEASURE, 16'($urandom), 16'($urandom), 8'($urandom),
						2'($urandom));
					k++;
				end
			endcase
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		opcode      = OP_MEASURE;
		frequency   = 16'd0;
		gap_um      = 16'd0;
		point_index = 8'd0;
		metal       = METAL_FE;
		out_stall   = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = REG_AIR_FREQ;
		cfg_data    = 16'd0;
		idle_pct    = 0;
		stall_pct   = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty tables: air band and missing calibration
		write_reg(REG_AIR_FREQ, 16'd30000);
		write_reg(REG_AIR_MARGIN, 16'd1000);
		send_beat(OP_MEASURE, 16'd0, 16'd0, 8'd0, METAL_FE);
		send_beat(OP_MEASURE, 16'd30000, 16'd0, 8'd0, METAL_FE);
		send_beat(OP_MEASURE, 16'hFFFF, 16'hFFFF, 8'hFF, 2'd3);
		// bad index, bad metal
		send_beat(OP_CALIB, 16'd100, 16'd5, 8'd20, METAL_FE);
		send_beat(OP_CALIB, 16'd100, 16'd5, 8'hFF, 2'd3);
		send_beat(OP_CALIB, 16'd100, 16'd5, 8'd3, 2'd2);
		send_beat(OP_CALIB, 16'd100, 16'd5, 8'd3, 2'd3);
		// ferrous table
		send_beat(OP_CALIB, 16'd1000, 16'd0, 8'd0, METAL_FE);
		send_beat(OP_CALIB, 16'd5000, 16'd2000, 8'd1, METAL_FE);
		send_beat(OP_CALIB, 16'd9000, 16'hFFFF, 8'd2, METAL_FE);
		send_beat(OP_MEASURE, 16'd500, 16'd0, 8'd0, METAL_FE);
		send_beat(OP_MEASURE, 16'd3001, 16'd0, 8'd0, METAL_FE);
		send_beat(OP_MEASURE, 16'd8999, 16'd0, 8'd0, METAL_FE);
		send_beat(OP_MEASURE, 16'd40000, 16'd0, 8'd0, METAL_FE);
		// aluminum table with falling thickness
		send_beat(OP_CALIB, 16'd60000, 16'd3000, 8'd0, METAL_AL);
		send_beat(OP_CALIB, 16'd50000, 16'd100, 8'd1, METAL_AL);
		send_beat(OP_CALIB, 16'd40000, 16'd0, 8'd19, METAL_AL);
		send_beat(OP_MEASURE, 16'd65535, 16'd0, 8'd0, METAL_FE);
		send_beat(OP_MEASURE, 16'd55555, 16'd0, 8'd0, METAL_FE);
		send_beat(OP_MEASURE, 16'd20000, 16'd0, 8'd0, METAL_FE);
		drain();
		write_reg(REG_AIR_FREQ, 16'hFFFF);
		write_reg(REG_AIR_MARGIN, 16'hFFFF);
		send_beat(OP_MEASURE, 16'd20000, 16'd0, 8'd0, METAL_FE);
		send_beat(OP_CALIB, 16'd0, 16'd0, 8'd0, METAL_FE);
		send_beat(OP_CALIB, 16'd0, 16'd0, 8'd0, METAL_AL);
		send_beat(OP_MEASURE, 16'd20000, 16'd0, 8'd0, METAL_FE);
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 55; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 55; end
				3: begin idle_pct = 10; stall_pct = 10; end
				default: begin idle_pct = 0; stall_pct = 0; end
			endcase
			write_reg(REG_AIR_FREQ, (ph == 0) ? 16'd0 : 16'($urandom));
			write_reg(REG_AIR_MARGIN, (ph == 4) ? 16'd0 : 16'($urandom_range(0, 8000)));
			run_random(95);
			drain();
		end
		stall_pct = 0;
		drain();
		if (fail_count == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end
endmodule

FILE: sim.f
rtl/ttti_pkg.sv
rtl/ttti_front.sv
rtl/ttti_div.sv
rtl/ttti_back.sv
rtl/two_table_thickness_interpolator.sv
rtl/ttti_checker.sv
verif/ttti_checker.sv
verif/tb_two_table_thickness_interpolator.sv
